// ===== rtl/psv_pkg.sv =====
package psv_pkg;

	// item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	// one half turn of phase in Q26.38 degrees (180 * 2^38)
	localparam logic [45:0] MODQ = 46'd49478023249920;
	localparam logic [31:0] PI30 = 32'd3373259426;
	localparam logic [30:0] ONE30 = 31'h4000_0000;
	// ceil(2^33/180) == ceil(2^31/45)
	localparam logic [25:0] RECIP = 26'd47721859;
	// smallest multiple of 180 that lifts a 25-bit signed value to non-negative
	localparam logic [25:0] WRAP_OFS = 26'd16777260;

	// horner cells, first to last; a zero divisor passes the sine lane through
	localparam int N_CELLS = 5;
	localparam int DIV_SIN [N_CELLS] = '{72, 42, 20, 6, 0};
	localparam int DIV_COS [N_CELLS] = '{90, 56, 30, 12, 2};

	typedef struct packed {
		logic               mode;
		logic [5:0]         slot;
		logic signed [31:0] src_dec;
		logic signed [31:0] src_ra;
		logic [31:0]        src_flux;
		logic signed [31:0] u_coord;
		logic signed [31:0] v_coord;
	} item_t;

	typedef struct packed {
		logic signed [47:0] real_sum;
		logic signed [47:0] imag_sum;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic        last;
		logic        en;
		logic [31:0] flux;
	} tag_t;

	typedef struct packed {
		tag_t        tag;
		logic [1:0]  quad;
		logic        fold;
		logic [29:0] t;
		logic [29:0] t2;
		logic [30:0] ks;
		logic [30:0] kc;
	} cell_bus_t;

endpackage

// ===== rtl/psv_phase.sv =====
module psv_phase (
	input  logic               clk,
	input  logic               arst_n,
	input  psv_pkg::tag_t      tag,
	input  logic signed [31:0] dec,
	input  logic signed [31:0] ra,
	input  logic signed [31:0] u,
	input  logic signed [31:0] v,
	output psv_pkg::cell_bus_t bus
);

	psv_pkg::tag_t tag_pipe_q [2:13];

	logic signed [63:0] pu_s2, pv_s2;
	logic [51:0] qu_prod_s3, qv_prod_s3;
	logic [25:0] yu_s3, yv_s3;
	logic [37:0] lu_s3, lv_s3;
	logic [45:0] pu_s4, pv_s4;
	logic [45:0] s_s5;
	logic [45:0] x_s6;
	logic [44:0] hprod_s7;
	logic [18:0] zh_s7, zl_s7;
	logic [13:0] qh_s8, qh_s9;
	logic [24:0] y2_s8;
	logic [50:0] lprod_s9;
	logic [31:0] ph_s10;
	logic [61:0] aprod_s11;
	logic [1:0]  quad_s11, quad_s12, quad_s13;
	logic        fold_s11, fold_s12, fold_s13;
	logic [29:0] t_s12, t_s13;
	logic [59:0] tt_s13;

	logic [25:0] yu, yv;
	logic [18:0] quo_u, quo_v;
	logic [7:0]  rem_u, rem_v;
	logic [46:0] sum_w;
	logic [45:0] s_red, x_val, x_ofs;
	logic [13:0] qh;
	logic [5:0]  rh;
	logic [18:0] ql;
	logic [29:0] r, a;
	logic        fold;
	logic [62:0] t_rnd;
	logic [60:0] t2_rnd;

	// lift the degree count above 2^38 to non-negative before reducing mod 180
	assign yu = pu_s2[63:38] + psv_pkg::WRAP_OFS;
	assign yv = pv_s2[63:38] + psv_pkg::WRAP_OFS;
	assign quo_u = qu_prod_s3[51:33];
	assign quo_v = qv_prod_s3[51:33];
	assign rem_u = 8'(yu_s3 - 26'(quo_u) * 26'd180);
	assign rem_v = 8'(yv_s3 - 26'(quo_v) * 26'd180);

	assign sum_w = {1'b0, pu_s4} + {1'b0, pv_s4};
	assign s_red = (sum_w >= {1'b0, psv_pkg::MODQ}) ?
		46'(sum_w - {1'b0, psv_pkg::MODQ}) : sum_w[45:0];
	assign x_val = (s_s5 == '0) ? '0 : psv_pkg::MODQ - s_s5;
	assign x_ofs = x_s6 + 46'd5760;

	// divide by 45 in two digits of 19 bits
	assign qh = hprod_s7[44:31];
	assign rh = 6'(zh_s7 - 19'(qh) * 19'd45);
	assign ql = lprod_s9[49:31];

	assign r = ph_s10[29:0];
	assign fold = r[29];
	assign a = fold ? 30'(31'h4000_0000 - 31'(r)) : r;

	assign t_rnd = 63'(aprod_s11) + 63'h4000_0000;
	assign t2_rnd = 61'(tt_s13) + 61'h2000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 2; i <= 13; i++) tag_pipe_q[i] <= '0;
			bus <= '0;
			pu_s2 <= '0; pv_s2 <= '0;
			qu_prod_s3 <= '0; qv_prod_s3 <= '0;
			yu_s3 <= '0; yv_s3 <= '0; lu_s3 <= '0; lv_s3 <= '0;
			pu_s4 <= '0; pv_s4 <= '0;
			s_s5 <= '0; x_s6 <= '0;
			hprod_s7 <= '0; zh_s7 <= '0; zl_s7 <= '0;
			qh_s8 <= '0; y2_s8 <= '0; qh_s9 <= '0; lprod_s9 <= '0;
			ph_s10 <= '0; aprod_s11 <= '0;
			quad_s11 <= '0; quad_s12 <= '0; quad_s13 <= '0;
			fold_s11 <= 1'b0; fold_s12 <= 1'b0; fold_s13 <= 1'b0;
			t_s12 <= '0; t_s13 <= '0; tt_s13 <= '0;
		end else begin
			tag_pipe_q[2] <= tag;
			for (int i = 3; i <= 13; i++) tag_pipe_q[i] <= tag_pipe_q[i-1];

			pu_s2 <= u * dec;
			pv_s2 <= v * ra;

			qu_prod_s3 <= 52'(yu) * 52'(psv_pkg::RECIP);
			qv_prod_s3 <= 52'(yv) * 52'(psv_pkg::RECIP);
			yu_s3 <= yu;
			yv_s3 <= yv;
			lu_s3 <= pu_s2[37:0];
			lv_s3 <= pv_s2[37:0];

			pu_s4 <= {rem_u, lu_s3};
			pv_s4 <= {rem_v, lv_s3};

			s_s5 <= s_red;
			x_s6 <= x_val;

			hprod_s7 <= 45'(x_ofs[45:27]) * 45'(psv_pkg::RECIP);
			zh_s7 <= x_ofs[45:27];
			zl_s7 <= x_ofs[26:8];

			qh_s8 <= qh;
			y2_s8 <= {rh, zl_s7};

			qh_s9 <= qh_s8;
			lprod_s9 <= 51'(y2_s8) * 51'(psv_pkg::RECIP);

			ph_s10 <= 32'({qh_s9, ql});

			aprod_s11 <= 62'(a) * 62'(psv_pkg::PI30);
			quad_s11 <= ph_s10[31:30];
			fold_s11 <= fold;

			t_s12 <= t_rnd[60:31];
			quad_s12 <= quad_s11;
			fold_s12 <= fold_s11;

			tt_s13 <= 60'(t_s12) * 60'(t_s12);
			t_s13 <= t_s12;
			quad_s13 <= quad_s12;
			fold_s13 <= fold_s12;

			bus.tag <= tag_pipe_q[13];
			bus.quad <= quad_s13;
			bus.fold <= fold_s13;
			bus.t <= t_s13;
			bus.t2 <= t2_rnd[59:30];
			bus.ks <= psv_pkg::ONE30;
			bus.kc <= psv_pkg::ONE30;
		end
	end

endmodule

// ===== rtl/psv_cell.sv =====
module psv_cell #(
	parameter int DIV_S = 72,
	parameter int DIV_C = 90
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psv_pkg::cell_bus_t up,
	output psv_pkg::cell_bus_t down
);

	localparam int DS = (DIV_S == 0) ? 1 : DIV_S;
	localparam logic [36:0] RECIP_S = 37'(((64'd1 << 37) + 64'(DS) - 64'd1) / 64'(DS));
	localparam logic [36:0] RECIP_C = 37'(((64'd1 << 37) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));

	psv_pkg::cell_bus_t bus_s1, bus_s2, down_nxt;
	logic [60:0] ps_s1, pc_s1;
	logic [66:0] ms_s2, mc_s2;
	logic [61:0] ws_rnd, wc_rnd;

	// k' = 1 - round(t2 * k) / div
	assign ws_rnd = 62'(ps_s1) + 62'h2000_0000;
	assign wc_rnd = 62'(pc_s1) + 62'h2000_0000;

	always_comb begin
		down_nxt = bus_s2;
		down_nxt.ks = (DIV_S == 0) ? bus_s2.ks : psv_pkg::ONE30 - 31'(ms_s2[66:37]);
		down_nxt.kc = psv_pkg::ONE30 - 31'(mc_s2[66:37]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_s1 <= '0;
			bus_s2 <= '0;
			down <= '0;
			ps_s1 <= '0; pc_s1 <= '0;
			ms_s2 <= '0; mc_s2 <= '0;
		end else begin
			bus_s1 <= up;
			ps_s1 <= 61'(up.t2) * 61'(up.ks);
			pc_s1 <= 61'(up.t2) * 61'(up.kc);

			bus_s2 <= bus_s1;
			ms_s2 <= 67'(ws_rnd[59:30]) * 67'(RECIP_S);
			mc_s2 <= 67'(wc_rnd[59:30]) * 67'(RECIP_C);

			down <= down_nxt;
		end
	end

endmodule

// ===== rtl/psv_accum.sv =====
module psv_accum #(
	parameter int MAX_SOURCES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psv_pkg::cell_bus_t bus,
	output logic               done,
	output psv_pkg::result_t   result
);

	localparam int ACC_W = 49 + $clog2(MAX_SOURCES + 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(48'sh7FFF_FFFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(48'sh8000_0000_0000);

	psv_pkg::cell_bus_t bus_s1;
	psv_pkg::tag_t tag_s2, tag_s3;
	logic [60:0] sp_s1;
	logic [30:0] cs_mag_s2, sn_mag_s2;
	logic        cs_neg_s2, sn_neg_s2, cs_neg_s3, sn_neg_s3;
	logic [62:0] pre_s3, pim_s3;
	logic signed [ACC_W-1:0] re_q, im_q;

	logic [61:0] s_rnd;
	logic [30:0] s_val, sa, ca;
	logic [30:0] cs_mag, sn_mag;
	logic        cs_neg, sn_neg;
	logic [63:0] mre_rnd, mim_rnd;
	logic signed [ACC_W-1:0] term_re, term_im, re_nxt, im_nxt;

	function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] y;
		begin
			y = x;
			if (x > SAT_HI) y = SAT_HI;
			if (x < SAT_LO) y = SAT_LO;
			sat48 = y[47:0];
		end
	endfunction

	assign s_rnd = 62'(sp_s1) + 62'h2000_0000;
	assign s_val = s_rnd[60:30];
	assign sa = bus_s1.fold ? bus_s1.kc : s_val;
	assign ca = bus_s1.fold ? s_val : bus_s1.kc;

	always_comb begin
		case (bus_s1.quad)
			2'd0: begin
				sn_mag = sa; sn_neg = 1'b0; cs_mag = ca; cs_neg = 1'b0;
			end
			2'd1: begin
				sn_mag = ca; sn_neg = 1'b0; cs_mag = sa; cs_neg = 1'b1;
			end
			2'd2: begin
				sn_mag = sa; sn_neg = 1'b1; cs_mag = ca; cs_neg = 1'b1;
			end
			default: begin
				sn_mag = ca; sn_neg = 1'b1; cs_mag = sa; cs_neg = 1'b0;
			end
		endcase
	end

	// round to Q24.24, sign after rounding
	assign mre_rnd = 64'(pre_s3) + 64'h20_0000;
	assign mim_rnd = 64'(pim_s3) + 64'h20_0000;

	always_comb begin
		term_re = $signed({{(ACC_W-41){1'b0}}, mre_rnd[62:22]});
		term_im = $signed({{(ACC_W-41){1'b0}}, mim_rnd[62:22]});
		if (cs_neg_s3) term_re = -term_re;
		if (sn_neg_s3) term_im = -term_im;
		if (!tag_s3.en) begin
			term_re = '0;
			term_im = '0;
		end
		re_nxt = re_q + term_re;
		im_nxt = im_q + term_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_s1 <= '0;
			sp_s1 <= '0;
			tag_s2 <= '0; tag_s3 <= '0;
			cs_mag_s2 <= '0; sn_mag_s2 <= '0;
			cs_neg_s2 <= 1'b0; sn_neg_s2 <= 1'b0;
			cs_neg_s3 <= 1'b0; sn_neg_s3 <= 1'b0;
			pre_s3 <= '0; pim_s3 <= '0;
			re_q <= '0; im_q <= '0;
			done <= 1'b0;
			result <= '0;
		end else begin
			bus_s1 <= bus;
			sp_s1 <= 61'(bus.t) * 61'(bus.ks);

			tag_s2 <= bus_s1.tag;
			cs_mag_s2 <= cs_mag; sn_mag_s2 <= sn_mag;
			cs_neg_s2 <= cs_neg; sn_neg_s2 <= sn_neg;

			tag_s3 <= tag_s2;
			pre_s3 <= 63'(tag_s2.flux) * 63'(cs_mag_s2);
			pim_s3 <= 63'(tag_s2.flux) * 63'(sn_mag_s2);
			cs_neg_s3 <= cs_neg_s2; sn_neg_s3 <= sn_neg_s2;

			done <= 1'b0;
			if (tag_s3.valid) begin
				if (tag_s3.last) begin
					re_q <= '0;
					im_q <= '0;
					done <= 1'b1;
					result.real_sum <= sat48(re_nxt);
					result.imag_sum <= sat48(im_nxt);
				end else begin
					re_q <= re_nxt;
					im_q <= im_nxt;
				end
			end
		end
	end

endmodule

// ===== rtl/point_source_visibility_sum.sv =====
// point-source visibility predictor. a load transaction (mode 0) writes one
// source slot and busy never rises. an evaluate transaction (mode 1) raises
// busy and streams the n = min(source_count, MAX_SOURCES) loaded slots, one
// per cycle, through the phase unit, a chain of five horner cells and the
// accumulator; done pulses for exactly one cycle with the saturated sums, and
// the receiver cannot stall it, so capture result on done. busy stays high
// until done, so no new transaction is taken before the last one is through;
// n = 0 counts as one slot.
module point_source_visibility_sum #(
	parameter int MAX_SOURCES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  psv_pkg::item_t   item,
	output logic             busy,
	input  logic             cfg_wr_en,
	input  logic [6:0]       cfg_wr_data,
	output logic             done,
	output psv_pkg::result_t result
);

	localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CNT_W = $clog2(MAX_SOURCES + 1);

	// source table: dec, ra, flux per slot
	logic [95:0] src_mem [MAX_SOURCES];
	logic [95:0] rd_s1;

	logic [6:0]       count_q;
	logic             busy_q, issue_q, zero_q;
	logic [CNT_W-1:0] idx_q, n_q, n_lim;
	logic             valid_s1, last_s1, en_s1;
	logic signed [31:0] u_q, v_q;

	logic accept, load_wr, eval_go, issue_last;
	psv_pkg::tag_t src_tag;
	psv_pkg::cell_bus_t chain [psv_pkg::N_CELLS+1];

	assign accept = start && !busy_q;
	assign load_wr = accept && (item.mode == psv_pkg::MODE_LOAD)
		&& (32'(item.slot) < 32'(MAX_SOURCES));
	assign eval_go = accept && (item.mode == psv_pkg::MODE_EVAL);
	assign busy = busy_q;

	// clamp the active count to the table depth
	assign n_lim = (32'(count_q) > 32'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES) : CNT_W'(count_q);
	assign issue_last = zero_q || ((32'(idx_q) + 32'd1) == 32'(n_q));

	// config register; the user must write it only while idle, nothing in the block enforces this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	// table write on load, one read per cycle while issuing
	always_ff @(posedge clk) begin
		if (load_wr) begin
			src_mem[IDX_W'(item.slot)] <= {item.src_dec, item.src_ra, item.src_flux};
		end
		rd_s1 <= src_mem[idx_q[IDX_W-1:0]];
	end

	// slot sequencer; an empty table still sends one disabled token to close the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			issue_q <= 1'b0;
			zero_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			u_q <= '0;
			v_q <= '0;
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			en_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue_q;
			last_s1 <= issue_q && issue_last;
			en_s1 <= issue_q && !zero_q;
			if (eval_go) begin
				busy_q <= 1'b1;
				issue_q <= 1'b1;
				idx_q <= '0;
				n_q <= n_lim;
				zero_q <= (n_lim == '0);
				u_q <= item.u_coord;
				v_q <= item.v_coord;
			end else begin
				if (issue_q) begin
					idx_q <= idx_q + CNT_W'(1);
					if (issue_last) issue_q <= 1'b0;
				end
				// result delivered, ready for the next transaction
				if (done) busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		src_tag.valid = valid_s1;
		src_tag.last = last_s1;
		src_tag.en = en_s1;
		src_tag.flux = rd_s1[31:0];
	end

	// phase turns, quadrant fold and angle
	psv_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (src_tag),
		.dec    (rd_s1[95:64]),
		.ra     (rd_s1[63:32]),
		.u      (u_q),
		.v      (v_q),
		.bus    (chain[0])
	);

	// horner chain for the sine and cosine series
	for (genvar i = 0; i < psv_pkg::N_CELLS; i++) begin : g_cell
		psv_cell #(
			.DIV_S (psv_pkg::DIV_SIN[i]),
			.DIV_C (psv_pkg::DIV_COS[i])
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.up     (chain[i]),
			.down   (chain[i+1])
		);
	end

	// flux scaling and the two running sums
	psv_accum #(
		.MAX_SOURCES (MAX_SOURCES)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.bus    (chain[psv_pkg::N_CELLS]),
		.done   (done),
		.result (result)
	);

endmodule
